### hdl/sdspi_pkg.sv
package sdspi_pkg;

	localparam int BLOCK_BYTES_DEF = 512;
	localparam logic [7:0] POLL_LIMIT_RST = 8'd32;

	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_RX   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INIT_ERR = 2'd1;
	localparam logic [1:0] ST_READ_ERR = 2'd2;
	localparam logic [1:0] ST_ZERO_CNT = 2'd3;

	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_IF_COND   = 6'd8;
	localparam logic [5:0] CMD_APP       = 6'd55;
	localparam logic [5:0] CMD_OP_COND   = 6'd41;
	localparam logic [5:0] CMD_READ_BLK  = 6'd17;

	localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
	localparam logic [31:0] ARG_OP_COND = 32'h4000_0000;

	localparam logic [7:0] BYTE_FILL   = 8'hFF;
	localparam logic [7:0] R1_IDLE     = 8'h01;
	localparam logic [7:0] R1_READY    = 8'h00;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [6:0] CRC7_POLY   = 7'h09;
	localparam int ECHO_BYTES = 4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FRAME,
		PH_RESP,
		PH_ECHO,
		PH_TOKEN,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] sector;
		logic [15:0] block_count;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       data_is_crc;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] card_response;
	} result_t;

	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] d;
		c = {1'b0, crc_in};
		d = b;
		for (int i = 0; i < 8; i++) begin
			c = {c[6:0], 1'b0};
			if (d[7] ^ c[7]) begin
				c = c ^ {1'b0, CRC7_POLY};
			end
			d = {d[6:0], 1'b0};
		end
		return c[6:0];
	endfunction

endpackage

### hdl/sdspi_engine.sv
module sdspi_engine #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sdspi_pkg::item_t   item,
	input  logic [7:0]         poll_limit,
	output sdspi_pkg::result_t res
);

	localparam int CNT_W = $clog2(BLOCK_BYTES + 3);
	localparam logic [CNT_W-1:0] BC_CRC  = CNT_W'(BLOCK_BYTES);
	localparam logic [CNT_W-1:0] BC_END  = CNT_W'(BLOCK_BYTES + 2);
	localparam logic [CNT_W-1:0] BC_ECHO = CNT_W'(sdspi_pkg::ECHO_BYTES);

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CMD,
		ACT_FRAME,
		ACT_RESP,
		ACT_ECHO,
		ACT_TOKEN,
		ACT_DATA,
		ACT_FILL,
		ACT_FINISH
	} act_t;

	sdspi_pkg::phase_t phase_q, phase_d;
	logic [2:0]       frame_pos_q, frame_pos_d;
	logic [5:0]       cmd_idx_q, cmd_idx_d;
	logic [31:0]      cmd_arg_q, cmd_arg_d;
	logic [6:0]       crc_q, crc_d;
	logic [7:0]       poll_cnt_q, poll_cnt_d;
	logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;
	logic [31:0]      sector_q, sector_d;
	logic [15:0]      blocks_q, blocks_d;
	logic [7:0]       last_resp_q, last_resp_d;

	act_t        act;
	logic [5:0]  new_idx;
	logic [31:0] new_arg;
	logic [1:0]  fin_status;
	logic        resp_upd;
	logic        pc_upd;
	logic        bc_inc;
	logic        data_out;
	logic        rd_load;
	logic        blk_next;

	logic [7:0]       pc_inc;
	logic             poll_done;
	logic [7:0]       resp;
	logic [CNT_W-1:0] bc_next;
	logic [15:0]      blocks_dec;
	logic [31:0]      sector_inc;
	logic [7:0]       frame_byte;

	assign pc_inc     = poll_cnt_q + 8'd1;
	assign poll_done  = (item.rx_byte != sdspi_pkg::BYTE_FILL) || (pc_inc >= poll_limit)
		|| (pc_inc == 8'd0);
	assign resp       = (item.rx_byte != sdspi_pkg::BYTE_FILL) ? item.rx_byte
		: sdspi_pkg::BYTE_FILL;
	assign bc_next    = byte_cnt_q + 1'b1;
	assign blocks_dec = blocks_q - 16'd1;
	assign sector_inc = sector_q + 32'd1;

	always_comb begin
		unique case (frame_pos_q)
			3'd0: frame_byte = sdspi_pkg::BYTE_FILL;
			3'd1: frame_byte = {2'b01, cmd_idx_q};
			3'd2: frame_byte = cmd_arg_q[31:24];
			3'd3: frame_byte = cmd_arg_q[23:16];
			3'd4: frame_byte = cmd_arg_q[15:8];
			3'd5: frame_byte = cmd_arg_q[7:0];
			default: frame_byte = {crc_q, 1'b1};
		endcase
	end

	// decision for the current item
	always_comb begin
		act        = ACT_NONE;
		new_idx    = sdspi_pkg::CMD_GO_IDLE;
		new_arg    = '0;
		fin_status = sdspi_pkg::ST_OK;
		resp_upd   = 1'b0;
		pc_upd     = 1'b0;
		bc_inc     = 1'b0;
		data_out   = 1'b0;
		rd_load    = 1'b0;
		blk_next   = 1'b0;
		priority if (item.opcode == sdspi_pkg::OP_INIT) begin
			act     = ACT_CMD;
			new_idx = sdspi_pkg::CMD_GO_IDLE;
		end else if (item.opcode == sdspi_pkg::OP_READ) begin
			if (item.block_count == 16'd0) begin
				act        = ACT_FINISH;
				fin_status = sdspi_pkg::ST_ZERO_CNT;
			end else begin
				act     = ACT_CMD;
				rd_load = 1'b1;
				new_idx = sdspi_pkg::CMD_READ_BLK;
				new_arg = item.sector;
			end
		end else if (item.opcode == sdspi_pkg::OP_RX) begin
			unique case (phase_q)
				sdspi_pkg::PH_FRAME: begin
					act = (frame_pos_q == 3'd7) ? ACT_RESP : ACT_FRAME;
				end
				sdspi_pkg::PH_RESP: begin
					pc_upd = (item.rx_byte == sdspi_pkg::BYTE_FILL);
					if (!poll_done) begin
						act = ACT_FILL;
					end else begin
						resp_upd = 1'b1;
						unique case (cmd_idx_q)
							sdspi_pkg::CMD_GO_IDLE: begin
								if (resp == sdspi_pkg::R1_IDLE) begin
									act     = ACT_CMD;
									new_idx = sdspi_pkg::CMD_IF_COND;
									new_arg = sdspi_pkg::ARG_IF_COND;
								end else begin
									act        = ACT_FINISH;
									fin_status = sdspi_pkg::ST_INIT_ERR;
								end
							end
							sdspi_pkg::CMD_IF_COND: begin
								if (resp == sdspi_pkg::R1_IDLE) begin
									act = ACT_ECHO;
								end else begin
									act        = ACT_FINISH;
									fin_status = sdspi_pkg::ST_INIT_ERR;
								end
							end
							sdspi_pkg::CMD_APP: begin
								act     = ACT_CMD;
								new_idx = sdspi_pkg::CMD_OP_COND;
								new_arg = sdspi_pkg::ARG_OP_COND;
							end
							sdspi_pkg::CMD_OP_COND: begin
								if (resp == sdspi_pkg::R1_READY) begin
									act        = ACT_FINISH;
									fin_status = sdspi_pkg::ST_OK;
								end else if (resp == sdspi_pkg::R1_IDLE) begin
									act     = ACT_CMD;
									new_idx = sdspi_pkg::CMD_APP;
								end else begin
									act        = ACT_FINISH;
									fin_status = sdspi_pkg::ST_INIT_ERR;
								end
							end
							default: begin
								if (resp != sdspi_pkg::BYTE_FILL) begin
									act = ACT_TOKEN;
								end else begin
									act        = ACT_FINISH;
									fin_status = sdspi_pkg::ST_READ_ERR;
								end
							end
						endcase
					end
				end
				sdspi_pkg::PH_ECHO: begin
					bc_inc = 1'b1;
					if (bc_next < BC_ECHO) begin
						act = ACT_FILL;
					end else begin
						act     = ACT_CMD;
						new_idx = sdspi_pkg::CMD_APP;
					end
				end
				sdspi_pkg::PH_TOKEN: begin
					pc_upd = (item.rx_byte == sdspi_pkg::BYTE_FILL);
					if (!poll_done) begin
						act = ACT_FILL;
					end else begin
						resp_upd = 1'b1;
						if (resp == sdspi_pkg::TOKEN_START) begin
							act = ACT_DATA;
						end else begin
							act        = ACT_FINISH;
							fin_status = sdspi_pkg::ST_READ_ERR;
						end
					end
				end
				sdspi_pkg::PH_DATA: begin
					data_out = 1'b1;
					bc_inc   = 1'b1;
					if (bc_next < BC_END) begin
						act = ACT_FILL;
					end else begin
						blk_next = 1'b1;
						if (blocks_dec == 16'd0) begin
							act        = ACT_FINISH;
							fin_status = sdspi_pkg::ST_OK;
						end else begin
							act     = ACT_CMD;
							new_idx = sdspi_pkg::CMD_READ_BLK;
							new_arg = sector_inc;
						end
					end
				end
				default: act = ACT_NONE;
			endcase
		end else begin
			act = ACT_NONE;
		end
	end

	// next phase
	always_comb begin
		unique case (act)
			ACT_CMD, ACT_FRAME: phase_d = sdspi_pkg::PH_FRAME;
			ACT_RESP:           phase_d = sdspi_pkg::PH_RESP;
			ACT_ECHO:           phase_d = sdspi_pkg::PH_ECHO;
			ACT_TOKEN:          phase_d = sdspi_pkg::PH_TOKEN;
			ACT_DATA:           phase_d = sdspi_pkg::PH_DATA;
			ACT_FINISH:         phase_d = sdspi_pkg::PH_IDLE;
			default:            phase_d = phase_q;
		endcase
	end

	// result and datapath
	always_comb begin
		frame_pos_d = frame_pos_q;
		cmd_idx_d   = cmd_idx_q;
		cmd_arg_d   = cmd_arg_q;
		crc_d       = crc_q;
		poll_cnt_d  = pc_upd ? pc_inc : poll_cnt_q;
		byte_cnt_d  = bc_inc ? bc_next : byte_cnt_q;
		sector_d    = sector_q;
		blocks_d    = blocks_q;
		last_resp_d = resp_upd ? resp : last_resp_q;
		res         = '0;

		if (rd_load) begin
			sector_d = item.sector;
			blocks_d = item.block_count;
		end
		if (blk_next) begin
			sector_d = sector_inc;
			blocks_d = blocks_dec;
		end
		if (data_out) begin
			res.data_valid  = 1'b1;
			res.data_byte   = item.rx_byte;
			res.data_is_crc = (byte_cnt_q >= BC_CRC);
		end

		unique case (act)
			ACT_CMD: begin
				cmd_idx_d   = new_idx;
				cmd_arg_d   = new_arg;
				crc_d       = '0;
				frame_pos_d = 3'd1;
				res.tx_valid = 1'b1;
				res.tx_byte  = sdspi_pkg::BYTE_FILL;
			end
			ACT_FRAME: begin
				if (frame_pos_q >= 3'd1 && frame_pos_q <= 3'd5) begin
					crc_d = sdspi_pkg::crc7_byte(crc_q, frame_byte);
				end
				frame_pos_d  = frame_pos_q + 3'd1;
				res.tx_valid = 1'b1;
				res.tx_byte  = frame_byte;
			end
			ACT_RESP, ACT_TOKEN: begin
				poll_cnt_d   = '0;
				res.tx_valid = 1'b1;
				res.tx_byte  = sdspi_pkg::BYTE_FILL;
			end
			ACT_ECHO, ACT_DATA: begin
				byte_cnt_d   = '0;
				res.tx_valid = 1'b1;
				res.tx_byte  = sdspi_pkg::BYTE_FILL;
			end
			ACT_FILL: begin
				res.tx_valid = 1'b1;
				res.tx_byte  = sdspi_pkg::BYTE_FILL;
			end
			ACT_FINISH: begin
				res.done_res = 1'b1;
				res.status   = fin_status;
			end
			default: ;
		endcase

		res.card_response = last_resp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdspi_pkg::PH_IDLE;
			frame_pos_q <= '0;
			cmd_idx_q   <= '0;
			cmd_arg_q   <= '0;
			crc_q       <= '0;
			poll_cnt_q  <= '0;
			byte_cnt_q  <= '0;
			sector_q    <= '0;
			blocks_q    <= '0;
			last_resp_q <= sdspi_pkg::BYTE_FILL;
		end else if (en) begin
			phase_q     <= phase_d;
			frame_pos_q <= frame_pos_d;
			cmd_idx_q   <= cmd_idx_d;
			cmd_arg_q   <= cmd_arg_d;
			crc_q       <= crc_d;
			poll_cnt_q  <= poll_cnt_d;
			byte_cnt_q  <= byte_cnt_d;
			sector_q    <= sector_d;
			blocks_q    <= blocks_d;
			last_resp_q <= last_resp_d;
		end
	end

	a_frame_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sdspi_pkg::PH_FRAME |-> frame_pos_q != 3'd0)
		else $error("frame position zero inside a command frame");

	a_data_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sdspi_pkg::PH_DATA |-> byte_cnt_q < BC_END)
		else $error("block byte count past end of block");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.done_res |=> phase_q == sdspi_pkg::PH_IDLE)
		else $error("operation finished but engine not idle");

	a_idle_rx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		en && phase_q == sdspi_pkg::PH_IDLE && item.opcode == sdspi_pkg::OP_RX
		|-> !res.tx_valid && !res.data_valid && !res.done_res)
		else $error("received byte while idle produced activity");

	a_data_only_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.data_valid |-> phase_q == sdspi_pkg::PH_DATA && !$isunknown(byte_cnt_q))
		else $error("data byte outside block phase");

endmodule

### hdl/sd_spi_startup_and_block_read_core.sv
// channel  | direction | signals                              | contents
// s_       | in        | s_tvalid s_tready s_tdata s_tuser    | host request or received MISO byte
// m_       | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | next MOSI byte, block data, status
// cfg_     | in        | cfg_valid cfg_ready cfg_data         | poll limit
//
// one item per clock sustained while the m_ side is not stalled; each result is registered at the output
// the per-item state update of the command engine sets the rate
// an input register and an output register part the two sides, so a stalled m_ side
// still lets one more item in
// arst_n clears all control state; the poll limit resets to 32
module sd_spi_startup_and_block_read_core #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // sector[31:0], block_count[47:32], rx_byte[55:48]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // tx_byte[7:0], data_byte[15:8], status[17:16],
	                               // card_response[25:18], zero[31:26]
	output logic [2:0]  m_tuser,   // tx_valid[0], data_valid[1], data_is_crc[2]
	output logic        m_tlast,   // done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic               valid_s1;
	sdspi_pkg::item_t   item_s1;
	logic               out_valid_q;
	sdspi_pkg::result_t res_q;
	sdspi_pkg::result_t res;
	logic [7:0]         poll_limit_q;
	logic               adv;

	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= sdspi_pkg::POLL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			poll_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode      <= s_tuser;
			item_s1.sector      <= s_tdata[31:0];
			item_s1.block_count <= s_tdata[47:32];
			item_s1.rx_byte     <= s_tdata[55:48];
		end
	end

	sdspi_engine #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.item       (item_s1),
		.poll_limit (poll_limit_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q.card_response, res_q.status, res_q.data_byte, res_q.tx_byte};
	assign m_tuser  = {res_q.data_is_crc, res_q.data_valid, res_q.tx_valid};
	assign m_tlast  = res_q.done_res;

endmodule

### bench/sd_spi_startup_and_block_read_core_tb.sv
`timescale 1ns / 100ps

module sd_spi_startup_and_block_read_core_tb;

	localparam int BLK = sdspi_pkg::BLOCK_BYTES_DEF;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // sector[31:0], block_count[47:32], rx_byte[55:48]
	logic [1:0]  s_tuser = '0;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // tx_byte[7:0], data_byte[15:8], status[17:16],
	                             // card_response[25:18]
	logic [2:0]  m_tuser;        // tx_valid[0], data_valid[1], data_is_crc[2]
	logic        m_tlast;        // done_res
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	sd_spi_startup_and_block_read_core #(.BLOCK_BYTES(BLK)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// host state as the block should hold it
	sdspi_pkg::phase_t  ph = sdspi_pkg::PH_IDLE;
	logic [2:0]         fpos = '0;
	logic [5:0]         cmd_idx = '0;
	logic [31:0]        cmd_arg = '0;
	logic [6:0]         crc = '0;
	logic [7:0]         polls = '0;
	int                 bcnt = 0;
	logic [31:0]        cur_sec = '0;
	logic [15:0]        blk_left = '0;
	logic [7:0]         last_resp = sdspi_pkg::BYTE_FILL;
	logic [7:0]         poll_lim = sdspi_pkg::POLL_LIMIT_RST;
	sdspi_pkg::result_t step_out;

	sdspi_pkg::result_t host_out_q[$];
	int n_fail = 0;
	int n_sent = 0;
	int src_gap_pct = 0;
	int snk_stall_pct = 0;
	int hold_cnt = 0;
	int stall_cycles = 0;
	bit card_mute = 1'b0;
	bit card_clean = 1'b0;

	function automatic logic [6:0] crc7_next(logic [6:0] c, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = b[i] ^ c[6];
			c = {c[5:0], 1'b0};
			if (fb) c = c ^ sdspi_pkg::CRC7_POLY;
		end
		return c;
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		step_out.tx_valid = 1'b1;
		step_out.tx_byte = b;
	endfunction

	function automatic void end_op(logic [1:0] st);
		step_out.done_res = 1'b1;
		step_out.status = st;
		step_out.tx_valid = 1'b0;
		step_out.tx_byte = '0;
		ph = sdspi_pkg::PH_IDLE;
	endfunction

	function automatic void frame_byte_out();
		logic [7:0] b;
		if (fpos == 3'd0) b = sdspi_pkg::BYTE_FILL;
		else if (fpos == 3'd1) b = {2'b01, cmd_idx};
		else if (fpos <= 3'd5) b = 8'(cmd_arg >> (8 * (5 - int'(fpos))));
		else b = {crc, 1'b1};
		if (fpos >= 3'd1 && fpos <= 3'd5) crc = crc7_next(crc, b);
		emit_byte(b);
		fpos = fpos + 3'd1;
	endfunction

	function automatic void issue_cmd(logic [5:0] idx, logic [31:0] arg);
		cmd_idx = idx;
		cmd_arg = arg;
		crc = '0;
		fpos = '0;
		ph = sdspi_pkg::PH_FRAME;
		frame_byte_out();
	endfunction

	function automatic bit poll_done(input logic [7:0] rx, output logic [7:0] resp);
		if (rx != sdspi_pkg::BYTE_FILL) begin
			resp = rx;
			return 1'b1;
		end
		polls = polls + 8'd1;
		if (polls >= poll_lim || polls == 8'd0) begin
			resp = sdspi_pkg::BYTE_FILL;
			return 1'b1;
		end
		emit_byte(sdspi_pkg::BYTE_FILL);
		return 1'b0;
	endfunction

	function automatic void on_resp(logic [7:0] resp);
		case (cmd_idx)
			sdspi_pkg::CMD_GO_IDLE: begin
				if (resp == sdspi_pkg::R1_IDLE)
					issue_cmd(sdspi_pkg::CMD_IF_COND, sdspi_pkg::ARG_IF_COND);
				else end_op(sdspi_pkg::ST_INIT_ERR);
			end
			sdspi_pkg::CMD_IF_COND: begin
				if (resp == sdspi_pkg::R1_IDLE) begin
					ph = sdspi_pkg::PH_ECHO;
					bcnt = 0;
					emit_byte(sdspi_pkg::BYTE_FILL);
				end else begin
					end_op(sdspi_pkg::ST_INIT_ERR);
				end
			end
			sdspi_pkg::CMD_APP: issue_cmd(sdspi_pkg::CMD_OP_COND, sdspi_pkg::ARG_OP_COND);
			sdspi_pkg::CMD_OP_COND: begin
				if (resp == sdspi_pkg::R1_READY) end_op(sdspi_pkg::ST_OK);
				else if (resp == sdspi_pkg::R1_IDLE) issue_cmd(sdspi_pkg::CMD_APP, 32'd0);
				else end_op(sdspi_pkg::ST_INIT_ERR);
			end
			default: begin
				if (resp != sdspi_pkg::BYTE_FILL) begin
					ph = sdspi_pkg::PH_TOKEN;
					polls = '0;
					emit_byte(sdspi_pkg::BYTE_FILL);
				end else begin
					end_op(sdspi_pkg::ST_READ_ERR);
				end
			end
		endcase
	endfunction

	function automatic sdspi_pkg::result_t sd_host_step(logic [1:0] op, logic [31:0] sec,
			logic [15:0] cnt, logic [7:0] rx);
		logic [7:0] resp;
		step_out = '0;
		case (op)
			sdspi_pkg::OP_INIT: issue_cmd(sdspi_pkg::CMD_GO_IDLE, 32'd0);
			sdspi_pkg::OP_READ: begin
				if (cnt == 16'd0) begin
					end_op(sdspi_pkg::ST_ZERO_CNT);
				end else begin
					cur_sec = sec;
					blk_left = cnt;
					issue_cmd(sdspi_pkg::CMD_READ_BLK, sec);
				end
			end
			sdspi_pkg::OP_RX: begin
				case (ph)
					sdspi_pkg::PH_FRAME: begin
						if (fpos == 3'd7) begin
							ph = sdspi_pkg::PH_RESP;
							polls = '0;
							emit_byte(sdspi_pkg::BYTE_FILL);
						end else begin
							frame_byte_out();
						end
					end
					sdspi_pkg::PH_RESP: begin
						if (poll_done(rx, resp)) begin
							last_resp = resp;
							on_resp(resp);
						end
					end
					sdspi_pkg::PH_ECHO: begin
						bcnt++;
						if (bcnt < sdspi_pkg::ECHO_BYTES) emit_byte(sdspi_pkg::BYTE_FILL);
						else issue_cmd(sdspi_pkg::CMD_APP, 32'd0);
					end
					sdspi_pkg::PH_TOKEN: begin
						if (poll_done(rx, resp)) begin
							last_resp = resp;
							if (resp == sdspi_pkg::TOKEN_START) begin
								ph = sdspi_pkg::PH_DATA;
								bcnt = 0;
								emit_byte(sdspi_pkg::BYTE_FILL);
							end else begin
								end_op(sdspi_pkg::ST_READ_ERR);
							end
						end
					end
					sdspi_pkg::PH_DATA: begin
						step_out.data_valid = 1'b1;
						step_out.data_byte = rx;
						step_out.data_is_crc = (bcnt >= BLK);
						bcnt++;
						if (bcnt < BLK + 2) begin
							emit_byte(sdspi_pkg::BYTE_FILL);
						end else begin
							blk_left = blk_left - 16'd1;
							cur_sec = cur_sec + 32'd1;
							if (blk_left == 16'd0) end_op(sdspi_pkg::ST_OK);
							else issue_cmd(sdspi_pkg::CMD_READ_BLK, cur_sec);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		step_out.card_response = last_resp;
		return step_out;
	endfunction

	// what a card would put on miso for the current host phase
	function automatic logic [7:0] card_reply();
		int roll;
		roll = $urandom_range(99);
		case (ph)
			sdspi_pkg::PH_RESP: begin
				if (card_mute) return sdspi_pkg::BYTE_FILL;
				if (!card_clean && roll < 30) return sdspi_pkg::BYTE_FILL;
				roll = $urandom_range(99);
				case (cmd_idx)
					sdspi_pkg::CMD_OP_COND: begin
						if (roll < 55) return sdspi_pkg::R1_IDLE;
						if (roll < 95 || card_clean) return sdspi_pkg::R1_READY;
						return 8'($urandom);
					end
					sdspi_pkg::CMD_READ_BLK: begin
						if (roll < 90 || card_clean) return sdspi_pkg::R1_READY;
						return 8'($urandom);
					end
					sdspi_pkg::CMD_APP: begin
						if (roll < 50 || card_clean) return sdspi_pkg::R1_IDLE;
						return 8'($urandom);
					end
					default: begin
						if (roll < 90 || card_clean) return sdspi_pkg::R1_IDLE;
						return 8'($urandom);
					end
				endcase
			end
			sdspi_pkg::PH_TOKEN: begin
				if (card_mute) return sdspi_pkg::BYTE_FILL;
				if (!card_clean && roll < 30) return sdspi_pkg::BYTE_FILL;
				if ($urandom_range(99) < 90 || card_clean) return sdspi_pkg::TOKEN_START;
				return 8'($urandom);
			end
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_sector();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return 32'hFFFF_FFFF;
		if (roll < 15) return 32'd0;
		return $urandom;
	endfunction

	function automatic logic [15:0] rand_count();
		int roll;
		roll = $urandom_range(99);
		if (roll < 87) return 16'd1;
		if (roll < 92) return 16'd2;
		return 16'($urandom_range(65535));
	endfunction

	task automatic send_req(logic [1:0] op, logic [31:0] sec, logic [15:0] cnt,
			logic [7:0] rx);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {rx, cnt, sec};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op != OP_NONE && !(op == sdspi_pkg::OP_RX && ph == sdspi_pkg::PH_IDLE)) n_sent++;
		host_out_q.push_back(sd_host_step(op, sec, cnt, rx));
	endtask

	task automatic card_exchange();
		send_req(sdspi_pkg::OP_RX, $urandom, 16'($urandom), card_reply());
	endtask

	task automatic start_startup();
		send_req(sdspi_pkg::OP_INIT, $urandom, 16'($urandom), 8'($urandom));
	endtask

	task automatic set_poll_limit(logic [7:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (host_out_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		poll_lim = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pacing(int src_pct, int snk_pct);
		src_gap_pct = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	// whole operations against a mostly well-behaved card, with restarts and noise
	task automatic run_card_ops(int n_items);
		int stop_at;
		int op_len;
		int pick;
		stop_at = n_sent + n_items;
		while (n_sent < stop_at) begin
			card_mute = ($urandom_range(99) < 6);
			pick = $urandom_range(99);
			if (pick < 55) start_startup();
			else if (pick < 80)
				send_req(sdspi_pkg::OP_READ, rand_sector(), rand_count(), 8'($urandom));
			else if (pick < 85)
				send_req(sdspi_pkg::OP_READ, $urandom, 16'd0, 8'($urandom));
			else if (pick < 93)
				send_req(sdspi_pkg::OP_RX, $urandom, 16'($urandom), 8'($urandom));
			else send_req(OP_NONE, $urandom, 16'($urandom), 8'($urandom));
			op_len = 0;
			while (ph != sdspi_pkg::PH_IDLE) begin
				pick = $urandom_range(999);
				if (pick < 8 || op_len > 600) begin
					if ($urandom_range(1)) start_startup();
					else send_req(sdspi_pkg::OP_READ, rand_sector(), rand_count(), 8'($urandom));
					op_len = 0;
				end else if (pick < 14) begin
					send_req(OP_NONE, $urandom, 16'($urandom), 8'($urandom));
				end else begin
					card_exchange();
				end
				op_len++;
			end
		end
	endtask

	task automatic test_idle_requests();
		send_req(sdspi_pkg::OP_RX, 32'd0, 16'd0, 8'h00);
		send_req(sdspi_pkg::OP_RX, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_req(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_req(OP_NONE, 32'd0, 16'd0, 8'h00);
	endtask

	task automatic test_zero_count();
		send_req(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 16'd0, 8'hFF);
		send_req(sdspi_pkg::OP_READ, 32'd0, 16'd0, 8'h00);
	endtask

	task automatic test_restart_while_busy();
		send_req(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
		repeat (3) send_req(sdspi_pkg::OP_RX, 32'd0, 16'd0, 8'hFF);
		send_req(sdspi_pkg::OP_INIT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		repeat (3) send_req(sdspi_pkg::OP_RX, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
		send_req(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_req(sdspi_pkg::OP_RX, 32'd0, 16'd0, 8'hA5);
		send_req(sdspi_pkg::OP_READ, 32'h1234_5678, 16'd0, 8'hFF);
	endtask

	task automatic test_backpressure();
		set_pacing(0, 0);
		card_mute = 1'b0;
		start_startup();
		hold_cnt = 300;
		repeat (30) card_exchange();
		while (ph != sdspi_pkg::PH_IDLE) card_exchange();
	endtask

	task automatic test_sector_wrap();
		card_mute = 1'b0;
		card_clean = 1'b1;
		send_req(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 16'd2, 8'h00);
		while (ph != sdspi_pkg::PH_IDLE) card_exchange();
		card_clean = 1'b0;
	endtask

	task automatic test_random_traffic();
		int lim_tab[4] = '{1, 255, 0, 0};
		int src_tab[4] = '{0, 62, 0, 37};
		int snk_tab[4] = '{0, 0, 62, 37};
		lim_tab[3] = $urandom_range(2, 254);
		for (int i = 0; i < 4; i++) begin
			set_poll_limit(8'(lim_tab[i]));
			set_pacing(src_tab[i], snk_tab[i]);
			run_card_ops(40);
		end
		set_poll_limit(sdspi_pkg::POLL_LIMIT_RST);
		set_pacing(0, 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_requests();
		test_zero_count();
		test_restart_while_busy();
		test_backpressure();
		test_sector_wrap();
		test_random_traffic();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (host_out_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	task automatic check_field(string fname, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", fname, want, seen);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin : host_out_check
		sdspi_pkg::result_t got;
		sdspi_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			got.tx_valid = m_tuser[0];
			got.tx_byte = m_tdata[7:0];
			got.data_valid = m_tuser[1];
			got.data_byte = m_tdata[15:8];
			got.data_is_crc = m_tuser[2];
			got.done_res = m_tlast;
			got.status = m_tdata[17:16];
			got.card_response = m_tdata[25:18];
			if (host_out_q.size() == 0) begin
				$error("transfer with no request pending: tdata %h tuser %h", m_tdata, m_tuser);
				n_fail++;
			end else begin
				want = host_out_q.pop_front();
				check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
				check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
				check_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
				check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
				check_field("data_is_crc", 32'(want.data_is_crc), 32'(got.data_is_crc));
				check_field("done_res", 32'(want.done_res), 32'(got.done_res));
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("card_response", 32'(want.card_response),
					32'(got.card_response));
			end
		end
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

### sim.f
hdl/sdspi_pkg.sv
hdl/sdspi_engine.sv
hdl/sd_spi_startup_and_block_read_core.sv
bench/sd_spi_startup_and_block_read_core_tb.sv
